[rtl/cau_pkg.sv]
// Shared types, opcodes, constants and saturation helper for the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_W           = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int ANG_FRAC         = 32;
    localparam int VEC_SHIFT        = 24;
    localparam int XY_W             = 58;
    localparam int Z_W              = 42;
    localparam int Q_W              = 41;

    localparam logic [XY_W-1:0] INV_GAIN_Q30 = 58'd652032874;

    typedef logic [2:0] op_t;

    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SUB   = 3'd1;
    localparam op_t OP_MUL   = 3'd2;
    localparam op_t OP_DIV   = 3'd3;
    localparam op_t OP_POLAR = 3'd4;
    localparam op_t OP_RECT  = 3'd5;

    // Arctangent of 2^-i in degrees, scaled by 2^32.
    localparam logic [39:0] ATAN_TAB [0:31] = '{
        40'd193273528320, 40'd114096026022, 40'd60285206653, 40'd30601712202,
        40'd15360239180,  40'd7687607525,   40'd3844741810,  40'd1922488225,
        40'd961258780,    40'd480631223,    40'd240315841,   40'd120157949,
        40'd60078978,     40'd30039490,     40'd15019745,    40'd7509872,
        40'd3754936,      40'd1877468,      40'd938734,      40'd469367,
        40'd234684,       40'd117342,       40'd58671,       40'd29335,
        40'd14668,        40'd7334,         40'd3667,        40'd1833,
        40'd917,          40'd458,          40'd229,         40'd115
    };

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } sat_t;

    // Everything one item carries through the long iteration chain.
    typedef struct packed {
        op_t             op;
        logic            dz;
        logic            ovf_s;
        logic [31:0]     s_re;
        logic [31:0]     s_im;
        logic            neg_re;
        logic            neg_im;
        logic [63:0]     den;
        logic [63:0]     num_re;
        logic [63:0]     num_im;
        logic [63:0]     rem_re;
        logic [63:0]     rem_im;
        logic [Q_W-1:0]  quo_re;
        logic [Q_W-1:0]  quo_im;
        logic            big_re;
        logic            big_im;
        logic [63:0]     sq_n;
        logic [63:0]     sq_r;
        logic [31:0]     a_re;
        logic [31:0]     a_im;
        logic [31:0]     ang_mag;
        logic            vec_zero;
        logic            flip;
        logic [XY_W-1:0] cx;
        logic [XY_W-1:0] cy;
        logic [Z_W-1:0]  cz;
    } chain_t;

    // Saturates a sign and magnitude pair to the signed 32-bit range.
    function automatic sat_t sat32(input logic neg, input logic [64:0] mag);
        sat_t r;
        if (!neg) begin
            if (mag > 65'h7FFFFFFF) begin
                r.ovf = 1'b1;
                r.val = 32'h7FFFFFFF;
            end
            else begin
                r.ovf = 1'b0;
                r.val = mag[31:0];
            end
        end
        else begin
            if (mag > 65'h80000000) begin
                r.ovf = 1'b1;
                r.val = 32'h80000000;
            end
            else begin
                r.ovf = 1'b0;
                r.val = ~mag[31:0] + 32'd1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/cau_stage.sv]
// One step of the iteration chain: a divider bit and, by position, a square root digit, angle reduction or CORDIC.
module cau_stage #(
    parameter int K            = 0,
    parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
    input  cau_pkg::chain_t d,
    output cau_pkg::chain_t q
);
    import cau_pkg::*;

    localparam int MOD_STEPS = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 1;
    localparam int SQ_SH     = (K < 32) ? 62 - 2 * K : 0;
    localparam int MOD_SH    = (K < MOD_STEPS) ? MOD_STEPS - 1 - K : 0;
    localparam int CI        = (K > MOD_STEPS) ? K - MOD_STEPS - 1 : 0;
    localparam int CI_T      = (CI < 32) ? CI : 31;

    localparam logic [33:0] MOD_M      = 34'd360 << FRAC_BITS;
    localparam logic [33:0] MOD_STEP_M = MOD_M << MOD_SH;

    localparam logic signed [34:0] HALF_F    = 35'sd180 <<< FRAC_BITS;
    localparam logic signed [34:0] FULL_F    = 35'sd360 <<< FRAC_BITS;
    localparam logic signed [34:0] QUARTER_F = 35'sd90 <<< FRAC_BITS;
    localparam logic signed [Z_W-1:0] Z_HALF = 42'sd180 <<< ANG_FRAC;

    logic [64:0]           dr_re;
    logic [64:0]           dr_im;
    logic                  ge_re;
    logic                  ge_im;
    logic [Q_W-1:0]        qs_re;
    logic [Q_W-1:0]        qs_im;
    logic [63:0]           sq_bit;
    logic [64:0]           sq_t;
    logic signed [34:0]    rs;
    logic                  rflip;
    logic signed [Z_W-1:0] rz;
    logic signed [XY_W-1:0] vx;
    logic signed [XY_W-1:0] vy;
    logic signed [Z_W-1:0]  vz;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  tab;
    logic                   up;

    assign dr_re  = {d.rem_re, d.num_re[63]};
    assign dr_im  = {d.rem_im, d.num_im[63]};
    assign ge_re  = dr_re >= {1'b0, d.den};
    assign ge_im  = dr_im >= {1'b0, d.den};
    assign qs_re  = {d.quo_re[Q_W-2:0], ge_re};
    assign qs_im  = {d.quo_im[Q_W-2:0], ge_im};
    assign sq_bit = 64'd1 << SQ_SH;
    assign sq_t   = {1'b0, d.sq_r} + {1'b0, sq_bit};
    assign dx     = $signed(d.cy) >>> CI;
    assign dy     = $signed(d.cx) >>> CI;
    assign tab    = $signed({2'b00, ATAN_TAB[CI_T]});
    assign up     = (d.op == OP_POLAR) ? !d.cy[XY_W-1] : d.cz[Z_W-1];

    // Angle for rotation: fold into [-180, 180), then into [-90, 90] with a flip.
    always_comb
    begin
        rs    = $signed({3'b000, d.ang_mag});
        rflip = 1'b0;
        if (d.a_im[31]) begin
            rs = -rs;
        end
        if (rs >= HALF_F) begin
            rs = rs - FULL_F;
        end
        else if (rs < -HALF_F) begin
            rs = rs + FULL_F;
        end
        if (rs > QUARTER_F) begin
            rs    = rs - HALF_F;
            rflip = 1'b1;
        end
        else if (rs < -QUARTER_F) begin
            rs    = rs + HALF_F;
            rflip = 1'b1;
        end
        rz = Z_W'(rs) <<< (ANG_FRAC - FRAC_BITS);
    end

    // Vectoring start: move a left half-plane vector to the right half-plane.
    always_comb
    begin
        vx = XY_W'($signed(d.a_re)) <<< VEC_SHIFT;
        vy = XY_W'($signed(d.a_im)) <<< VEC_SHIFT;
        vz = '0;
        if (d.a_re[31]) begin
            vx = -vx;
            vy = -vy;
            vz = d.a_im[31] ? -Z_HALF : Z_HALF;
        end
    end

    always_comb
    begin
        q = d;

        q.num_re = {d.num_re[62:0], 1'b0};
        q.num_im = {d.num_im[62:0], 1'b0};
        q.rem_re = ge_re ? 64'(dr_re - {1'b0, d.den}) : dr_re[63:0];
        q.rem_im = ge_im ? 64'(dr_im - {1'b0, d.den}) : dr_im[63:0];
        if (!d.big_re) begin
            q.quo_re = qs_re;
            q.big_re = qs_re[Q_W-1];
        end
        if (!d.big_im) begin
            q.quo_im = qs_im;
            q.big_im = qs_im[Q_W-1];
        end

        if (K < 32) begin
            if ({1'b0, d.sq_n} >= sq_t) begin
                q.sq_n = d.sq_n - sq_t[63:0];
                q.sq_r = (d.sq_r >> 1) + sq_bit;
            end
            else begin
                q.sq_r = d.sq_r >> 1;
            end
        end

        if (K < MOD_STEPS) begin
            if ({2'b00, d.ang_mag} >= MOD_STEP_M) begin
                q.ang_mag = 32'({2'b00, d.ang_mag} - MOD_STEP_M);
            end
        end

        if (K == MOD_STEPS) begin
            if (d.op == OP_POLAR) begin
                q.cx       = vx;
                q.cy       = vy;
                q.cz       = vz;
                q.flip     = 1'b0;
                q.vec_zero = (d.a_re == 32'd0) && (d.a_im == 32'd0);
            end
            else begin
                q.cx       = INV_GAIN_Q30;
                q.cy       = '0;
                q.cz       = rz;
                q.flip     = rflip;
                q.vec_zero = 1'b0;
            end
        end

        if ((K > MOD_STEPS) && (CI < CORDIC_STEPS) && (CI < 32)) begin
            if (up) begin
                q.cx = $signed(d.cx) + dx;
                q.cy = $signed(d.cy) - dy;
                q.cz = $signed(d.cz) + tab;
            end
            else begin
                q.cx = $signed(d.cx) - dx;
                q.cy = $signed(d.cy) + dy;
                q.cz = $signed(d.cz) - tab;
            end
        end
    end

endmodule

[rtl/complex_arithmetic_unit_core.sv]
// Top level of the pipelined complex arithmetic unit.
//
//  channel | signals                                   | beat moves when
//  --------+-------------------------------------------+----------------------
//  input   | op, a_re, a_im, b_re, b_im                | in_valid & in_ready
//  output  | res_re, res_im, overflow, div_by_zero     | out_valid & out_ready
//
// Every beat passes three front stages, 64 + FRAC_BITS chain stages and three back
// stages on its way from acceptance to the output register. The chain length is
// set by the restoring divider, one quotient bit per stage. One beat can enter in
// every cycle while the output is not stalled.
// Reset clears only the valid bits; the data registers hold whatever they had.
// A stall on the output freezes the whole pipeline at once, so nothing is lost
// or repeated, and in_ready falls only while a finished beat waits unaccepted.
//
// Front stages: the six 32x32 products, then the sums, then rounding of add,
// subtract and multiply results. The chain runs the divider for both quotient
// parts, the square root of the magnitude, the angle reduction for rectangular
// conversion and a shared CORDIC (vectoring for polar, rotation for rectangular).
// Back stages: quotient and root rounding plus the magnitude products, absolute
// values, and the final rounding, saturation and opcode select.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cau_pkg::op_t        op,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  res_re,
    output logic signed [31:0]  res_im,
    output logic                overflow,
    output logic                div_by_zero
);
    import cau_pkg::*;

    localparam int CH_LEN = 64 + FRAC_BITS;
    localparam logic [64:0]    RND_F  = 65'd1 << (FRAC_BITS - 1);
    localparam logic [64:0]    RND_Z  = 65'd1 << (ANG_FRAC - FRAC_BITS - 1);
    localparam logic [64:0]    RND_30 = 65'd1 << 29;
    localparam logic [Q_W-1:0] Q_CAP  = 41'd1 << (Q_W - 1);

    logic en;

    // Front stage one: products.
    logic               p1_vld_reg;
    op_t                p1_op_reg;
    logic signed [31:0] p1_are_reg, p1_aim_reg, p1_bre_reg, p1_bim_reg;
    logic signed [63:0] p1_pab_reg, p1_pcd_reg, p1_pad_reg, p1_pcb_reg;
    logic signed [63:0] p1_sq0_reg, p1_sq1_reg;
    logic signed [31:0] sq_x, sq_y;

    // Front stage two: sums.
    logic               p2_vld_reg;
    op_t                p2_op_reg;
    logic signed [31:0] p2_are_reg, p2_aim_reg;
    logic signed [64:0] p2_sre_reg, p2_sim_reg;
    logic signed [64:0] p2_sre_next, p2_sim_next;
    logic [63:0]        p2_den_reg;

    // Front stage three feeds the chain.
    logic        neg_re, neg_im;
    logic [64:0] mag_re, mag_im, rnd_re, rnd_im;
    sat_t        sat_re, sat_im;
    chain_t      c0;

    chain_t      ch_reg  [0:CH_LEN];
    chain_t      ch_next [0:CH_LEN-1];
    logic [CH_LEN:0] ch_vld_reg;
    chain_t      e;

    // Back stage one.
    logic               q1_vld_reg;
    op_t                q1_op_reg;
    logic               q1_dz_reg, q1_ovf_reg, q1_neg_re_reg, q1_neg_im_reg, q1_vzero_reg;
    logic [31:0]        q1_s_re_reg, q1_s_im_reg;
    logic [Q_W-1:0]     q1_qre_reg, q1_qim_reg, q1_qre_next, q1_qim_next;
    logic [32:0]        q1_sq_reg, q1_sq_next;
    logic [Z_W-1:0]     q1_z_reg;
    logic signed [63:0] q1_pre_reg, q1_pim_reg;
    logic signed [XY_W-1:0] fx_re, fx_im;

    // Back stage two.
    logic               q2_vld_reg;
    op_t                q2_op_reg;
    logic               q2_dz_reg, q2_ovf_reg, q2_neg_re_reg, q2_neg_im_reg, q2_vzero_reg;
    logic [31:0]        q2_s_re_reg, q2_s_im_reg;
    logic [Q_W-1:0]     q2_qre_reg, q2_qim_reg;
    logic [32:0]        q2_sq_reg;
    logic               q2_zneg_reg, q2_pneg_re_reg, q2_pneg_im_reg;
    logic [Z_W-1:0]     q2_zmag_reg;
    logic [63:0]        q2_pmag_re_reg, q2_pmag_im_reg;

    // Output register.
    logic               out_vld_reg;
    logic [31:0]        res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic               ovf_reg, ovf_next, dz_reg, dz_next;
    sat_t               f_re, f_im;

    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign overflow  = ovf_reg;
    assign div_by_zero = dz_reg;

    // Squares serve the divisor norm for divide and the magnitude for polar.
    assign sq_x = (op == OP_DIV) ? b_re : a_re;
    assign sq_y = (op == OP_DIV) ? b_im : a_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            ch_vld_reg  <= '0;
            q1_vld_reg  <= 1'b0;
            q2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en) begin
            p1_vld_reg  <= in_valid;
            p2_vld_reg  <= p1_vld_reg;
            ch_vld_reg  <= {ch_vld_reg[CH_LEN-1:0], p2_vld_reg};
            q1_vld_reg  <= ch_vld_reg[CH_LEN];
            q2_vld_reg  <= q1_vld_reg;
            out_vld_reg <= q2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            p1_op_reg  <= op;
            p1_are_reg <= a_re;
            p1_aim_reg <= a_im;
            p1_bre_reg <= b_re;
            p1_bim_reg <= b_im;
            p1_pab_reg <= a_re * b_re;
            p1_pcd_reg <= a_im * b_im;
            p1_pad_reg <= a_re * b_im;
            p1_pcb_reg <= a_im * b_re;
            p1_sq0_reg <= sq_x * sq_x;
            p1_sq1_reg <= sq_y * sq_y;
        end
    end

    always_comb
    begin
        case (p1_op_reg)
            OP_ADD:
            begin
                p2_sre_next = 65'(p1_are_reg) + 65'(p1_bre_reg);
                p2_sim_next = 65'(p1_aim_reg) + 65'(p1_bim_reg);
            end
            OP_SUB:
            begin
                p2_sre_next = 65'(p1_are_reg) - 65'(p1_bre_reg);
                p2_sim_next = 65'(p1_aim_reg) - 65'(p1_bim_reg);
            end
            OP_MUL:
            begin
                p2_sre_next = 65'(p1_pab_reg) - 65'(p1_pcd_reg);
                p2_sim_next = 65'(p1_pad_reg) + 65'(p1_pcb_reg);
            end
            OP_DIV:
            begin
                p2_sre_next = 65'(p1_pab_reg) + 65'(p1_pcd_reg);
                p2_sim_next = 65'(p1_pcb_reg) - 65'(p1_pad_reg);
            end
            default:
            begin
                p2_sre_next = '0;
                p2_sim_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            p2_op_reg  <= p1_op_reg;
            p2_are_reg <= p1_are_reg;
            p2_aim_reg <= p1_aim_reg;
            p2_sre_reg <= p2_sre_next;
            p2_sim_reg <= p2_sim_next;
            p2_den_reg <= $unsigned(p1_sq0_reg) + $unsigned(p1_sq1_reg);
        end
    end

    // Sign and magnitude of the sums; add, subtract and multiply finish here.
    always_comb
    begin
        neg_re = p2_sre_reg[64];
        neg_im = p2_sim_reg[64];
        mag_re = neg_re ? 65'(-p2_sre_reg) : p2_sre_reg;
        mag_im = neg_im ? 65'(-p2_sim_reg) : p2_sim_reg;
        if (p2_op_reg == OP_MUL) begin
            rnd_re = (mag_re + RND_F) >> FRAC_BITS;
            rnd_im = (mag_im + RND_F) >> FRAC_BITS;
        end
        else begin
            rnd_re = mag_re;
            rnd_im = mag_im;
        end
        sat_re = sat32(neg_re, rnd_re);
        sat_im = sat32(neg_im, rnd_im);

        c0          = '0;
        c0.op       = p2_op_reg;
        c0.dz       = (p2_op_reg == OP_DIV) && (p2_den_reg == 64'd0);
        c0.ovf_s    = sat_re.ovf | sat_im.ovf;
        c0.s_re     = sat_re.val;
        c0.s_im     = sat_im.val;
        c0.neg_re   = neg_re;
        c0.neg_im   = neg_im;
        c0.den      = p2_den_reg;
        c0.num_re   = mag_re[63:0];
        c0.num_im   = mag_im[63:0];
        c0.sq_n     = p2_den_reg;
        c0.a_re     = p2_are_reg;
        c0.a_im     = p2_aim_reg;
        c0.ang_mag  = p2_aim_reg[31] ? 32'(-p2_aim_reg) : p2_aim_reg;
    end

    for (genvar k = 0; k < CH_LEN; k++)
    begin : g_chain
        cau_stage #(
            .K            (k),
            .FRAC_BITS    (FRAC_BITS),
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_stage (
            .d (ch_reg[k]),
            .q (ch_next[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            ch_reg[0] <= c0;
            for (int k = 0; k < CH_LEN; k++) begin
                ch_reg[k+1] <= ch_next[k];
            end
        end
    end

    assign e = ch_reg[CH_LEN];

    // Quotient rounding (half up on the remainder), root rounding, and the
    // rotation result folded back by the half-turn flip.
    always_comb
    begin
        q1_qre_next = e.big_re ? Q_CAP
                               : e.quo_re + Q_W'(e.rem_re >= (e.den - e.rem_re));
        q1_qim_next = e.big_im ? Q_CAP
                               : e.quo_im + Q_W'(e.rem_im >= (e.den - e.rem_im));
        q1_sq_next  = {1'b0, e.sq_r[31:0]} + 33'(e.sq_n > e.sq_r);
        fx_re       = e.flip ? -$signed(e.cx) : $signed(e.cx);
        fx_im       = e.flip ? -$signed(e.cy) : $signed(e.cy);
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            q1_op_reg     <= e.op;
            q1_dz_reg     <= e.dz;
            q1_ovf_reg    <= e.ovf_s;
            q1_s_re_reg   <= e.s_re;
            q1_s_im_reg   <= e.s_im;
            q1_neg_re_reg <= e.neg_re;
            q1_neg_im_reg <= e.neg_im;
            q1_vzero_reg  <= e.vec_zero;
            q1_qre_reg    <= q1_qre_next;
            q1_qim_reg    <= q1_qim_next;
            q1_sq_reg     <= q1_sq_next;
            q1_z_reg      <= e.cz;
            q1_pre_reg    <= $signed(e.a_re) * $signed(fx_re[31:0]);
            q1_pim_reg    <= $signed(e.a_re) * $signed(fx_im[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            q2_op_reg      <= q1_op_reg;
            q2_dz_reg      <= q1_dz_reg;
            q2_ovf_reg     <= q1_ovf_reg;
            q2_s_re_reg    <= q1_s_re_reg;
            q2_s_im_reg    <= q1_s_im_reg;
            q2_neg_re_reg  <= q1_neg_re_reg;
            q2_neg_im_reg  <= q1_neg_im_reg;
            q2_vzero_reg   <= q1_vzero_reg;
            q2_qre_reg     <= q1_qre_reg;
            q2_qim_reg     <= q1_qim_reg;
            q2_sq_reg      <= q1_sq_reg;
            q2_zneg_reg    <= q1_z_reg[Z_W-1];
            q2_zmag_reg    <= q1_z_reg[Z_W-1] ? Z_W'(-$signed(q1_z_reg)) : q1_z_reg;
            q2_pneg_re_reg <= q1_pre_reg[63];
            q2_pneg_im_reg <= q1_pim_reg[63];
            q2_pmag_re_reg <= q1_pre_reg[63] ? 64'(-q1_pre_reg) : q1_pre_reg;
            q2_pmag_im_reg <= q1_pim_reg[63] ? 64'(-q1_pim_reg) : q1_pim_reg;
        end
    end

    // Final rounding, saturation and opcode select.
    always_comb
    begin
        f_re        = '0;
        f_im        = '0;
        res_re_next = '0;
        res_im_next = '0;
        ovf_next    = 1'b0;
        dz_next     = 1'b0;
        case (q2_op_reg)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                res_re_next = q2_s_re_reg;
                res_im_next = q2_s_im_reg;
                ovf_next    = q2_ovf_reg;
            end
            OP_DIV:
            begin
                f_re = sat32(q2_neg_re_reg, 65'(q2_qre_reg));
                f_im = sat32(q2_neg_im_reg, 65'(q2_qim_reg));
                if (q2_dz_reg) begin
                    res_re_next = 32'h7FFFFFFF;
                    res_im_next = 32'h7FFFFFFF;
                    dz_next     = 1'b1;
                end
                else begin
                    res_re_next = f_re.val;
                    res_im_next = f_im.val;
                    ovf_next    = f_re.ovf | f_im.ovf;
                end
            end
            OP_POLAR:
            begin
                f_re = sat32(1'b0, 65'(q2_sq_reg));
                f_im = sat32(q2_zneg_reg,
                             (65'(q2_zmag_reg) + RND_Z) >> (ANG_FRAC - FRAC_BITS));
                res_re_next = f_re.val;
                if (q2_vzero_reg) begin
                    res_im_next = '0;
                    ovf_next    = f_re.ovf;
                end
                else begin
                    res_im_next = f_im.val;
                    ovf_next    = f_re.ovf | f_im.ovf;
                end
            end
            OP_RECT:
            begin
                f_re = sat32(q2_pneg_re_reg, (65'(q2_pmag_re_reg) + RND_30) >> 30);
                f_im = sat32(q2_pneg_im_reg, (65'(q2_pmag_im_reg) + RND_30) >> 30);
                res_re_next = f_re.val;
                res_im_next = f_im.val;
                ovf_next    = f_re.ovf | f_im.ovf;
            end
            default:
            begin
                res_re_next = '0;
                res_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            ovf_reg    <= ovf_next;
            dz_reg     <= dz_next;
        end
    end

endmodule

[bench/cau_checker.sv]
// Checker for the complex arithmetic unit: predicts each beat and compares results.
`timescale 1ns / 1ps

module cau_checker #(
    parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  cau_pkg::op_t       op,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] res_re,
    input  logic signed [31:0] res_im,
    input  logic               overflow,
    input  logic               div_by_zero,
    output int                 fail_count,
    output int                 pending
);
    import cau_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
        logic        dz;
    } cplx_result_t;

    cplx_result_t expected_results[$];

    // Rounds a magnitude to nearest (ties away from zero) after dropping s bits,
    // then saturates. Returns {overflow, value}.
    function automatic logic [32:0] round_clamp(bit neg, logic [65:0] mag, int s);
        logic [65:0] q;
        q = (s > 0) ? ((mag + (66'd1 << (s - 1))) >> s) : mag;
        if (!neg)
            return (q > 66'h7FFFFFFF) ? {1'b1, 32'h7FFFFFFF} : {1'b0, q[31:0]};
        if (q > 66'h80000000)
            return {1'b1, 32'h80000000};
        return {1'b0, 32'(-q)};
    endfunction

    function automatic logic [32:0] clamp_signed(logic signed [65:0] v, int s);
        return round_clamp(v < 0, (v < 0) ? 66'(-v) : 66'(v), s);
    endfunction

    // Restoring division giving round(mag * 2^FRAC_BITS / den), capped at 2^40.
    function automatic logic [65:0] scaled_quotient(logic [63:0] mag, logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        bit big;
        bit qb;
        r = '0;
        q = '0;
        big = 0;
        for (int j = 0; j < 64 + FRAC_BITS; j++) begin
            r = {r[63:0], (j < 64) ? mag[63-j] : 1'b0};
            qb = 0;
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                qb = 1;
            end
            if (!big) begin
                q = {q[62:0], qb};
                if (q >= (64'd1 << 40))
                    big = 1;
            end
        end
        if (big)
            return 66'd1 << 40;
        if (r >= ({1'b0, den} - r))
            q = q + 1;
        return {2'b0, q};
    endfunction

    function automatic logic [63:0] rounded_root(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (n > res)
            res = res + 1;
        return res;
    endfunction

    // Vectoring CORDIC: angle of (ar, ai) in degrees, Q16.16. Returns {overflow, value}.
    function automatic logic [32:0] polar_angle(longint ar, longint ai);
        longint x, y, z, dx, dy;
        x = ar * (longint'(1) << VEC_SHIFT);
        y = ai * (longint'(1) << VEC_SHIFT);
        z = 0;
        if (ar == 0 && ai == 0)
            return 33'd0;
        // Left half-plane: mirror through the origin and start from +/-180 degrees.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = (ai >= 0) ? (longint'(180) <<< ANG_FRAC) : -(longint'(180) <<< ANG_FRAC);
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
            else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return clamp_signed(66'(z), ANG_FRAC - FRAC_BITS);
    endfunction

    // Rotation CORDIC: r at angle ang degrees. Returns {ovf, re, im}.
    function automatic logic [64:0] rect_point(longint r, longint ang);
        longint full, half, quarter, x, y, z, dx, dy;
        logic [32:0] pr, pi;
        bit flip;
        full = longint'(360) <<< ANG_FRAC;
        half = longint'(180) <<< ANG_FRAC;
        quarter = longint'(90) <<< ANG_FRAC;
        z = ang * (longint'(1) << (ANG_FRAC - FRAC_BITS));
        x = longint'(INV_GAIN_Q30);
        y = 0;
        flip = 0;
        // Reduce to [-180, 180), then fold into the right half-plane.
        z = z % full;
        if (z >= half)
            z = z - full;
        if (z < -half)
            z = z + full;
        if (z > quarter) begin
            z = z - half;
            flip = 1;
        end
        else if (z < -quarter) begin
            z = z + half;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        pr = clamp_signed(66'(r * x), 30);
        pi = clamp_signed(66'(r * y), 30);
        return {pr[32] | pi[32], pr[31:0], pi[31:0]};
    endfunction

    function automatic cplx_result_t predict_result(op_t code, logic signed [31:0] xr,
                                                    logic signed [31:0] xi,
                                                    logic signed [31:0] yr,
                                                    logic signed [31:0] yi);
        cplx_result_t e;
        logic signed [65:0] ar, ai, br, bi, nre, nim;
        logic [65:0] den;
        logic [32:0] pr, pi;
        logic [64:0] pt;
        ar = xr;
        ai = xi;
        br = yr;
        bi = yi;
        e = '{re: '0, im: '0, ovf: 1'b0, dz: 1'b0};
        pr = '0;
        pi = '0;
        case (code)
            OP_ADD: begin
                pr = clamp_signed(ar + br, 0);
                pi = clamp_signed(ai + bi, 0);
            end
            OP_SUB: begin
                pr = clamp_signed(ar - br, 0);
                pi = clamp_signed(ai - bi, 0);
            end
            OP_MUL: begin
                pr = clamp_signed(ar * br - ai * bi, FRAC_BITS);
                pi = clamp_signed(ar * bi + ai * br, FRAC_BITS);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    e.dz = 1'b1;
                    pr = {1'b0, 32'h7FFFFFFF};
                    pi = {1'b0, 32'h7FFFFFFF};
                end
                else begin
                    nre = ar * br + ai * bi;
                    nim = ai * br - ar * bi;
                    pr = round_clamp(nre < 0,
                        scaled_quotient((nre < 0) ? 64'(-nre) : 64'(nre), den[63:0]), 0);
                    pi = round_clamp(nim < 0,
                        scaled_quotient((nim < 0) ? 64'(-nim) : 64'(nim), den[63:0]), 0);
                end
            end
            OP_POLAR: begin
                den = ar * ar + ai * ai;
                pr = round_clamp(1'b0, {2'b0, rounded_root(den[63:0])}, 0);
                pi = polar_angle(longint'(xr), longint'(xi));
            end
            OP_RECT: begin
                pt = rect_point(longint'(xr), longint'(xi));
                pr = {pt[64], pt[63:32]};
                pi = {1'b0, pt[31:0]};
            end
            default: ;
        endcase
        e.re = pr[31:0];
        e.im = pi[31:0];
        e.ovf = pr[32] | pi[32];
        return e;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk) begin
        cplx_result_t want;
        if (!rst_n) begin
            fail_count <= 0;
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_result(op, a_re, a_im, b_re, b_im));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat: re=%h im=%h", res_re, res_im);
                end
                else begin
                    want = expected_results.pop_front();
                    if (want.re !== res_re || want.im !== res_im ||
                        want.ovf !== overflow || want.dz !== div_by_zero) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: expected re=%h im=%h ovf=%b dz=%b, ",
                                      "got re=%h im=%h ovf=%b dz=%b"},
                                     want.re, want.im, want.ovf, want.dz,
                                     res_re, res_im, overflow, div_by_zero);
                    end
                end
            end
        end
    end

endmodule

[bench/testbench.sv]
// Top of the complex arithmetic unit bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import cau_pkg::*;

    localparam int RANDOM_BEATS = 1950;
    // Past this many sent beats neither side idles any more.
    localparam int QUIET_FROM   = 1750;
    localparam int CYCLE_LIMIT  = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    op_t                op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               overflow;
    logic               div_by_zero;
    int                 fail_count;
    int                 pending;
    int                 beats_sent;
    int                 cycles = 0;
    bit                 quiet;
    bit                 long_hold_done = 1'b0;

    complex_arithmetic_unit_core dut (.*);

    cau_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .out_valid(out_valid),
        .out_ready(out_ready), .res_re(res_re), .res_im(res_im), .overflow(overflow),
        .div_by_zero(div_by_zero), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: the slowest correct run is far below this many cycles.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one beat. With idling allowed, a random burst of empty cycles may come first.
    task automatic send_beat(op_t code, logic [31:0] xr, logic [31:0] xi,
                             logic [31:0] yr, logic [31:0] yi);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        a_re <= xr;
        a_im <= xi;
        b_re <= yr;
        b_im <= yi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        quiet = beats_sent >= QUIET_FROM;
    endtask

    // Operand value: full 32-bit range, moderate Q16.16 values, or an edge value.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2, 3:    return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
            4:       return 32'($signed($urandom_range(0, 32'h0001FFFF)) - 32'sh00010000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h00000000;
                    1: return 32'h7FFFFFFF;
                    2: return 32'h80000000;
                    3: return 32'hFFFFFFFF;
                    default: return 32'h00010000;
                endcase
            end
        endcase
    endfunction

    // The receiver stalls in short random bursts, and once for a long stretch so
    // that the pipeline fills and in_ready has to drop.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!long_hold_done && beats_sent >= 200) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                out_ready <= 1'b1;
                long_hold_done = 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial begin
        op_t code;
        logic [31:0] xr;
        logic [31:0] xi;
        beats_sent = 0;
        quiet = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_ADD;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: extremes, every opcode and the corner cases.
        send_beat(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
        send_beat(OP_ADD, 32'h00010000, 32'hFFFF0000, 32'h00028000, 32'h00000000);
        send_beat(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        send_beat(OP_SUB, 32'h00030000, 32'h00000000, 32'h00010000, 32'h00020000);
        send_beat(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_beat(OP_MUL, 32'h00018000, 32'h00020000, 32'hFFFF0000, 32'h00008000);
        send_beat(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_beat(OP_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
        send_beat(OP_DIV, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
        send_beat(OP_DIV, 32'h00050000, 32'hFFFD0000, 32'h00020000, 32'h00000000);
        send_beat(OP_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'h00000000);
        send_beat(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_beat(OP_POLAR, 32'h00000000, 32'h00000000, 32'h0, 32'h0);
        send_beat(OP_POLAR, 32'hFFFD0000, 32'h00040000, 32'h0, 32'h0);
        send_beat(OP_POLAR, 32'hFFFF0000, 32'h00000000, 32'h0, 32'h0);
        send_beat(OP_POLAR, 32'hFFFF0000, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_beat(OP_POLAR, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        send_beat(OP_POLAR, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0);
        send_beat(OP_RECT, 32'h00020000, 32'h002D0000, 32'h0, 32'h0);
        send_beat(OP_RECT, 32'h00020000, 32'h01FE0000, 32'h0, 32'h0);
        send_beat(OP_RECT, 32'hFFFE0000, 32'hFF100000, 32'h0, 32'h0);
        send_beat(OP_RECT, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
        send_beat(OP_RECT, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
        send_beat(op_t'(6), 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0);
        send_beat(op_t'(7), 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // Unknown opcodes only now and then; most beats use the six operations.
            code = ($urandom_range(0, 31) == 0) ? op_t'($urandom_range(6, 7))
                                                : op_t'($urandom_range(0, 5));
            xr = pick_operand();
            xi = pick_operand();
            // Rectangular conversion mostly gets angles within a few turns.
            if (code == OP_RECT && $urandom_range(0, 2) != 0)
                xi = 32'($signed($urandom_range(0, 1440 << 16)) - (720 <<< 16));
            send_beat(code, xr, xi, pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[complex_arithmetic_unit_core.f]
rtl/cau_pkg.sv
rtl/cau_stage.sv
rtl/complex_arithmetic_unit_core.sv
bench/cau_checker.sv
bench/testbench.sv
